// ===== sv/jsld_pkg.sv =====
// Shared types and constants of the joint stiffness loss detector.
`timescale 1ns / 1ps

package jsld_pkg;

  // Number of joints tracked and the widths that follow from the fields.
  localparam int unsigned NumJoints   = 26;
  localparam int unsigned JointIdxW   = 5;
  localparam int unsigned AngleW      = 16;
  localparam int unsigned CurrentW    = 13;
  localparam int unsigned CountW      = 16;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 26;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned InUserW     = 1;
  localparam int unsigned OutDataW    = 8;

  // Saturation value of the hit and miss counters.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_ANGLE_THRESHOLD    = 3'd0,
    CFG_CURRENT_THRESHOLD  = 3'd1,
    CFG_MAX_MISSES         = 3'd2,
    CFG_HITS_FOR_DETECTION = 3'd3,
    CFG_DISABLED_MASK      = 3'd4
  } cfg_addr_e;

  // Configuration register set.
  typedef struct packed {
    logic [AngleW-1:0]    angle_threshold;
    logic [CurrentW-1:0]  current_threshold;
    logic [CountW-1:0]    max_misses;
    logic [CountW-1:0]    hits_for_detection;
    logic [NumJoints-1:0] disabled_mask;
  } cfg_t;

  // One joint sample.
  typedef struct packed {
    logic [JointIdxW-1:0] joint_index;
    logic [AngleW-1:0]    angle_error;
    logic [CurrentW-1:0]  motor_current;
    logic                 body_dead;
    logic                 first_of_frame;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic joint_loss;
    logic frame_loss;
  } result_t;

  // Saturating increment of a counter.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + CountW'(1);
  endfunction

endpackage

// ===== sv/jsld_core.sv =====
// Per-joint hit and miss counters, frame flag and the loss decision.
`timescale 1ns / 1ps

module jsld_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  jsld_pkg::sample_t sample_i,
  input  jsld_pkg::cfg_t    cfg_i,
  output jsld_pkg::result_t result_o
);

  logic [jsld_pkg::CountW-1:0] hit_q  [jsld_pkg::NumJoints];
  logic [jsld_pkg::CountW-1:0] miss_q [jsld_pkg::NumJoints];
  logic                        frame_q, frame_d;

  logic [jsld_pkg::NumJoints-1:0] sel;
  logic [jsld_pkg::CountW-1:0]    hit_rd, miss_rd, hit_nx, miss_nx;
  logic                           disabled, active, loss;

  // Decode the joint index and pick out its counters and mask bit.
  always_comb begin
    hit_rd   = '0;
    miss_rd  = '0;
    disabled = 1'b0;
    for (int j = 0; j < jsld_pkg::NumJoints; j++) begin
      sel[j] = (sample_i.joint_index == jsld_pkg::JointIdxW'(j));
      if (sel[j]) begin
        hit_rd   = hit_q[j];
        miss_rd  = miss_q[j];
        disabled = cfg_i.disabled_mask[j];
      end
    end
  end

  // A sample counts only for an enabled, in-range joint while the body moves.
  assign active = (|sel) && !disabled && !sample_i.body_dead;

  // Hit and miss update, then the miss limit and the detection check.
  always_comb begin
    hit_nx  = hit_rd;
    miss_nx = miss_rd;
    if (sample_i.angle_error > cfg_i.angle_threshold) begin
      if (sample_i.motor_current < cfg_i.current_threshold) begin
        hit_nx  = jsld_pkg::sat_inc(hit_rd);
        miss_nx = '0;
      end
    end else begin
      miss_nx = jsld_pkg::sat_inc(miss_rd);
    end
    if (miss_nx > cfg_i.max_misses) begin
      hit_nx = '0;
    end
    loss = active && (hit_nx > cfg_i.hits_for_detection);
  end

  // Frame flag: cleared by the first sample of a frame, set by any loss.
  always_comb begin
    frame_d = sample_i.first_of_frame ? 1'b0 : frame_q;
    if (loss) begin
      frame_d = 1'b1;
    end
  end

  assign result_o.joint_loss = loss;
  assign result_o.frame_loss = frame_d;

  // Counter bank write-back for the selected joint.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < jsld_pkg::NumJoints; j++) begin
        hit_q[j]  <= '0;
        miss_q[j] <= '0;
      end
      frame_q <= 1'b0;
    end else if (upd_i) begin
      for (int j = 0; j < jsld_pkg::NumJoints; j++) begin
        if (sel[j] && active) begin
          hit_q[j]  <= hit_nx;
          miss_q[j] <= miss_nx;
        end
      end
      frame_q <= frame_d;
    end
  end

endmodule

// ===== sv/joint_stiffness_loss_detector_unit.sv =====
// Top level of the joint stiffness loss detector with stream ports.
// A sample passes the input register, then the result register, where its result sets tvalid.
// One sample per cycle while results flow; the counter read-modify-write is combinational.
// The input register still takes a sample while a result waits, as long as it holds none.
// Reset (rst_ni low, asynchronous) clears all counters, the frame flag,
// the configuration registers and both valid flags.
`timescale 1ns / 1ps

module joint_stiffness_loss_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [jsld_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [jsld_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Sample stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // joint_index[4:0], angle_error[20:5], motor_current[33:21], body_dead[34], zero[39:35]
  input  logic [jsld_pkg::InDataW-1:0]  s_axis_tdata_i,
  // first_of_frame[0]
  input  logic [jsld_pkg::InUserW-1:0]  s_axis_tuser_i,
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // joint_loss[0], frame_loss[1], zero[7:2]
  output logic [jsld_pkg::OutDataW-1:0] m_axis_tdata_o
);

  jsld_pkg::cfg_t    cfg_q;
  jsld_pkg::sample_t smp_q;
  jsld_pkg::result_t res_q, res_d;
  logic              smp_vld_q, res_vld_q;
  logic              out_ready, upd, in_acc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        jsld_pkg::CFG_ANGLE_THRESHOLD: begin
          cfg_q.angle_threshold <= cfg_wdata_i[jsld_pkg::AngleW-1:0];
        end
        jsld_pkg::CFG_CURRENT_THRESHOLD: begin
          cfg_q.current_threshold <= cfg_wdata_i[jsld_pkg::CurrentW-1:0];
        end
        jsld_pkg::CFG_MAX_MISSES: begin
          cfg_q.max_misses <= cfg_wdata_i[jsld_pkg::CountW-1:0];
        end
        jsld_pkg::CFG_HITS_FOR_DETECTION: begin
          cfg_q.hits_for_detection <= cfg_wdata_i[jsld_pkg::CountW-1:0];
        end
        jsld_pkg::CFG_DISABLED_MASK: begin
          cfg_q.disabled_mask <= cfg_wdata_i[jsld_pkg::NumJoints-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control.
  assign out_ready       = !res_vld_q || m_axis_tready_i;
  assign upd             = smp_vld_q && out_ready;
  assign s_axis_tready_o = !smp_vld_q || out_ready;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      smp_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q.joint_index    <= s_axis_tdata_i[4:0];
      smp_q.angle_error    <= s_axis_tdata_i[20:5];
      smp_q.motor_current  <= s_axis_tdata_i[33:21];
      smp_q.body_dead      <= s_axis_tdata_i[34];
      smp_q.first_of_frame <= s_axis_tuser_i[0];
    end
  end

  // Counter update and loss decision.
  jsld_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .sample_i (smp_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_ready) begin
      res_vld_q <= smp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = {6'b0, res_q.frame_loss, res_q.joint_loss};

endmodule

// ===== sv/jsld_checker.sv =====
// Port-level checks of the joint stiffness loss detector and their binding.
`timescale 1ns / 1ps

module jsld_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [jsld_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // A stalled result keeps its data until its transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A joint loss always shows in the frame flag of the same result.
  a_loss_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tdata_o[0] || m_axis_tdata_o[1]))
    else $error("joint loss without frame loss");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:2] == 6'b0))
    else $error("nonzero padding in result");

  // Input is refused only while a result is held back downstream.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

endmodule

bind joint_stiffness_loss_detector_unit jsld_checker u_jsld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== dv/jsld_tb_pkg.sv =====
// Scoreboard class that predicts and checks the stiffness loss results.
`timescale 1ns / 1ps

package jsld_tb_pkg;

  import jsld_pkg::*;

  class stiffness_scoreboard;

    // Register copies, written alongside the block's configuration port.
    logic [AngleW-1:0]    angle_limit;
    logic [CurrentW-1:0]  current_limit;
    logic [CountW-1:0]    miss_limit;
    logic [CountW-1:0]    hit_limit;
    logic [NumJoints-1:0] skip_mask;

    // Per-joint counters and the frame flag as the block should hold them.
    logic [CountW-1:0] hit_cnt[NumJoints];
    logic [CountW-1:0] miss_cnt[NumJoints];
    logic              frame_seen;

    // Results still owed by the block, oldest first.
    result_t           expected_losses[$];
    int unsigned       failures;

    function new();
      angle_limit   = '0;
      current_limit = '0;
      miss_limit    = '0;
      hit_limit     = '0;
      skip_mask     = '0;
      frame_seen    = 1'b0;
      failures      = 0;
      foreach (hit_cnt[j]) begin
        hit_cnt[j]  = '0;
        miss_cnt[j] = '0;
      end
    endfunction

    function void set_register(cfg_addr_e addr, logic [CfgDataW-1:0] value);
      case (addr)
        CFG_ANGLE_THRESHOLD:    angle_limit   = value[AngleW-1:0];
        CFG_CURRENT_THRESHOLD:  current_limit = value[CurrentW-1:0];
        CFG_MAX_MISSES:         miss_limit    = value[CountW-1:0];
        CFG_HITS_FOR_DETECTION: hit_limit     = value[CountW-1:0];
        CFG_DISABLED_MASK:      skip_mask     = value[NumJoints-1:0];
        default: ;
      endcase
    endfunction

    // Counters stick at their maximum instead of wrapping.
    function logic [CountW-1:0] bump(logic [CountW-1:0] v);
      return (v == {CountW{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Updates the joint state for one accepted sample and queues its result.
    function void note_sample(sample_t s);
      result_t     r;
      int unsigned j;
      r = '0;
      j = s.joint_index;
      if (s.first_of_frame) begin
        frame_seen = 1'b0;
      end
      // Out-of-range joints, masked joints and dead motion leave the counters alone.
      if (j < NumJoints) begin
        if (!skip_mask[j] && !s.body_dead) begin
          if (s.angle_error > angle_limit) begin
            if (s.motor_current < current_limit) begin
              hit_cnt[j]  = bump(hit_cnt[j]);
              miss_cnt[j] = '0;
            end
          end else begin
            miss_cnt[j] = bump(miss_cnt[j]);
          end
          if (miss_cnt[j] > miss_limit) begin
            hit_cnt[j] = '0;
          end
          r.joint_loss = (hit_cnt[j] > hit_limit);
        end
      end
      if (r.joint_loss) begin
        frame_seen = 1'b1;
      end
      r.frame_loss = frame_seen;
      expected_losses.push_back(r);
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(logic [OutDataW-1:0] data);
      result_t want;
      if (expected_losses.size() == 0) begin
        $error("result transaction with no sample waiting: tdata=%h", data);
        failures++;
        return;
      end
      want = expected_losses.pop_front();
      if (data[0] !== want.joint_loss) begin
        $error("joint_loss: expected %0b, actual %0b", want.joint_loss, data[0]);
        failures++;
      end
      if (data[1] !== want.frame_loss) begin
        $error("frame_loss: expected %0b, actual %0b", want.frame_loss, data[1]);
        failures++;
      end
      if (data[OutDataW-1:2] !== '0) begin
        $error("tdata padding: expected 0, actual %h", data[OutDataW-1:2]);
        failures++;
      end
    endfunction

  endclass

endpackage

// ===== dv/tb_top.sv =====
// Testbench top that drives joint samples through the loss detector and checks each result.
`timescale 1ns / 1ps

module tb_top;

  import jsld_pkg::*;
  import jsld_tb_pkg::*;

  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseItems = 180;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgAddrW-1:0]   cfg_addr;
  logic [CfgDataW-1:0]   cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata;
  logic [InUserW-1:0]    s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutDataW-1:0]   m_tdata;
  sample_t               s_item;

  stiffness_scoreboard   sb;
  bit                    tx_gaps;
  bit                    rx_gaps;
  bit                    long_hold_req;

  // Sample fields packed from the lowest bit up, padded to whole bytes.
  assign s_tdata = {5'b0, s_item.body_dead, s_item.motor_current,
                    s_item.angle_error, s_item.joint_index};
  assign s_tuser = s_item.first_of_frame;

  joint_stiffness_loss_detector_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // Clock generation.
  always #2 clk = ~clk;

  // Transaction monitor: results are checked before the new sample is noted.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
    end
    if (s_tvalid && s_tready) begin
      sb.note_sample(s_item);
    end
  end

  // Result receiver with random back-pressure and one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    #(6_000_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(input cfg_addr_e addr, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    sb.set_register(addr, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_config(input logic [AngleW-1:0] angle, input logic [CurrentW-1:0] amps,
                             input logic [CountW-1:0] misses, input logic [CountW-1:0] hits,
                             input logic [NumJoints-1:0] mask);
    write_reg(CFG_ANGLE_THRESHOLD, CfgDataW'(angle));
    write_reg(CFG_CURRENT_THRESHOLD, CfgDataW'(amps));
    write_reg(CFG_MAX_MISSES, CfgDataW'(misses));
    write_reg(CFG_HITS_FOR_DETECTION, CfgDataW'(hits));
    write_reg(CFG_DISABLED_MASK, CfgDataW'(mask));
  endtask

  // Offers one sample, maybe after an idle burst, and returns once it is taken.
  task automatic offer_sample(input sample_t s);
    int unsigned gap;
    gap = 0;
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
    end
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_item   <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has arrived.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_losses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic sample_t mk(input int unsigned j, input int unsigned err,
                                 input int unsigned amps, input bit dead, input bit first);
    sample_t s;
    s.joint_index    = JointIdxW'(j);
    s.angle_error    = AngleW'(err);
    s.motor_current  = CurrentW'(amps);
    s.body_dead      = dead;
    s.first_of_frame = first;
    return s;
  endfunction

  // Frame sample with the angle and current biased toward the thresholds.
  function automatic sample_t pick_sample(input int unsigned j, input bit first, input bit dead);
    int          v;
    int unsigned amps;
    case ($urandom_range(0, 2))
      0: begin
        v = int'(sb.angle_limit) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      1: v = $urandom_range(sb.angle_limit, 65535);
      default: v = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1) == 0) begin
      amps = $urandom_range(0, sb.current_limit);
    end else begin
      amps = $urandom_range(0, 8191);
    end
    return mk(j, v, amps, dead, first);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned len;
    int unsigned start;
    int unsigned k;
    bit          dead;
    bit          mid_drained;

    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_item        = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    long_hold_req = 1'b0;
    mid_drained   = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hits, misses, current at threshold, skips and field extremes.
    load_config(16'h1000, 13'd100, 16'd2, 16'd1, 26'h2000008);
    offer_sample(mk(0, 16'h2000, 50, 0, 1));
    offer_sample(mk(0, 16'h2000, 50, 0, 0));
    offer_sample(mk(1, 16'h2000, 100, 0, 0));
    offer_sample(mk(0, 16'h1000, 0, 0, 0));
    offer_sample(mk(0, 16'h0000, 0, 0, 0));
    offer_sample(mk(0, 16'h0000, 0, 0, 0));
    offer_sample(mk(3, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(5, 16'hFFFF, 0, 1, 0));
    offer_sample(mk(25, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(26, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(31, 16'hFFFF, 8191, 1, 1));
    offer_sample(mk(2, 16'h1000, 8191, 0, 1));
    offer_sample(mk(24, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(24, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(24, 16'hFFFF, 8191, 0, 0));
    offer_sample(mk(24, 16'h1001, 99, 0, 1));
    offer_sample(mk(0, 16'hFFFF, 0, 0, 0));
    offer_sample(mk(0, 16'h1001, 99, 0, 0));
    offer_sample(mk(0, 16'h0FFF, 99, 0, 1));

    // Random phases, mostly whole frames with some noise in between.
    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: load_config(16'd0, 13'd0, 16'd0, 16'd0, 26'd0);
        1: load_config(16'hFFFF, 13'h1FFF, 16'hFFFF, 16'hFFFF, 26'h3FFFFFF);
        2: load_config(AngleW'($urandom), CurrentW'($urandom), CountW'($urandom),
                       CountW'($urandom), NumJoints'($urandom));
        default: load_config(AngleW'($urandom), CurrentW'($urandom_range(1, 8191)),
                             CountW'($urandom_range(0, 4)), CountW'($urandom_range(0, 3)),
                             NumJoints'($urandom & $urandom & $urandom));
      endcase
      tx_gaps = (phase != 5) && ($urandom_range(0, 3) != 0);
      rx_gaps = (phase != 5) && ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        long_hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 6) == 0) begin
          offer_sample(mk($urandom_range(0, 31), $urandom_range(0, 65535),
                          $urandom_range(0, 8191), ($urandom_range(0, 1) == 1),
                          ($urandom_range(0, 1) == 1)));
          sent++;
        end else begin
          len   = $urandom_range(1, NumJoints);
          start = $urandom_range(0, NumJoints - len);
          dead  = ($urandom_range(0, 11) == 0);
          for (k = 0; k < len; k++) begin
            offer_sample(pick_sample(start + k, k == 0, dead));
          end
          sent += len;
        end
        // Once, the sender stops in mid-phase until the block has caught up.
        if (phase == 4 && !mid_drained && sent >= PhaseItems / 2) begin
          drain();
          mid_drained = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_losses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
